/* rtl/nar_pkg.sv */
// Shared types and constants for the null-aware run reducer.
package nar_pkg;

  // Lane tag codes
  localparam logic [1:0] KIND_KNOWN   = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_ABSENT  = 2'd2;

  // Mode register codes
  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_OR       = 3'd1;
  localparam logic [2:0] MODE_FIRST    = 3'd2;
  localparam logic [2:0] MODE_LARGEST  = 3'd3;
  localparam logic [2:0] MODE_LAST     = 3'd4;
  localparam logic [2:0] MODE_LOGIC_OR = 3'd5;
  localparam logic [2:0] MODE_RESIST   = 3'd6;
  localparam logic [2:0] MODE_SMALLEST = 3'd7;

  // Value limits
  localparam logic signed [31:0] ADD_TOP      = 32'sh7FFF_FFFD;
  localparam logic signed [31:0] VALUE_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] RESIST_LIMIT = 32'sd3;

  // Per-transaction control handed to each lane
  typedef struct packed {
    logic       en;
    logic       start;
    logic [2:0] mode;
  } lane_ctl_t;

endpackage

/* rtl/nar_lane.sv */
// One lane: accumulator state, load/combine logic and result formatting.
module nar_lane (
  input  logic                clk,
  input  logic                rst,
  input  nar_pkg::lane_ctl_t  ctl,
  input  logic signed [31:0]  value,
  input  logic [1:0]          kind,
  output logic signed [31:0]  result,
  output logic [1:0]          result_kind
);

  logic signed [31:0] acc, acc_next;
  logic [1:0]         acc_kind, acc_kind_next;
  logic signed [31:0] neg, neg_next;
  logic [1:0]         neg_kind, neg_kind_next;

  logic [1:0]         k;
  logic signed [33:0] sum;
  logic signed [31:0] comb;
  logic               is_resist;

  assign is_resist = (ctl.mode == nar_pkg::MODE_RESIST);

  // Kind code three counts as absent
  assign k = (kind == 2'd3) ? nar_pkg::KIND_ABSENT : kind;

  // Known-with-known combine for the plain modes
  assign sum = {{2{acc[31]}}, acc} + {{2{value[31]}}, value};
  always_comb begin
    case (ctl.mode)
      nar_pkg::MODE_ADD: begin
        if (!value[31] && (value != 32'sd0) &&
            (sum > $signed({{2{nar_pkg::ADD_TOP[31]}}, nar_pkg::ADD_TOP}))) begin
          comb = nar_pkg::ADD_TOP;
        end else if (value[31] &&
            (sum < $signed({{2{nar_pkg::VALUE_MIN[31]}}, nar_pkg::VALUE_MIN}))) begin
          comb = nar_pkg::VALUE_MIN;
        end else begin
          comb = sum[31:0];
        end
      end
      nar_pkg::MODE_OR:       comb = acc | value;
      nar_pkg::MODE_LARGEST:  comb = (acc < value) ? value : acc;
      nar_pkg::MODE_LOGIC_OR: comb = ((acc != 32'sd0) || (value != 32'sd0)) ? 32'sd1 : 32'sd0;
      default:                comb = (acc > value) ? value : acc;
    endcase
  end

  // Next state: load on run start, otherwise combine by mode
  always_comb begin
    acc_next      = acc;
    acc_kind_next = acc_kind;
    neg_next      = neg;
    neg_kind_next = neg_kind;
    if (ctl.start) begin
      neg_next      = 32'sd0;
      neg_kind_next = nar_pkg::KIND_ABSENT;
      if (k != nar_pkg::KIND_KNOWN) begin
        acc_next      = 32'sd0;
        acc_kind_next = k;
        if (is_resist) begin
          neg_kind_next = k;
        end
      end else begin
        acc_kind_next = nar_pkg::KIND_KNOWN;
        if (ctl.mode == nar_pkg::MODE_LOGIC_OR) begin
          acc_next = (value != 32'sd0) ? 32'sd1 : 32'sd0;
        end else if (is_resist) begin
          neg_kind_next = nar_pkg::KIND_KNOWN;
          if (value > 32'sd0) begin
            acc_next = value;
          end else begin
            acc_next = 32'sd0;
            neg_next = value;
          end
        end else begin
          acc_next = value;
        end
      end
    end else if (ctl.mode == nar_pkg::MODE_FIRST) begin
      // later items ignored
    end else if (ctl.mode == nar_pkg::MODE_LAST) begin
      acc_next      = (k == nar_pkg::KIND_KNOWN) ? value : 32'sd0;
      acc_kind_next = k;
    end else if (k == nar_pkg::KIND_ABSENT) begin
      // skipped
    end else if (k == nar_pkg::KIND_UNKNOWN) begin
      if (acc_kind == nar_pkg::KIND_ABSENT) begin
        acc_kind_next = nar_pkg::KIND_UNKNOWN;
        acc_next      = 32'sd0;
        if (is_resist) begin
          neg_kind_next = nar_pkg::KIND_UNKNOWN;
          neg_next      = 32'sd0;
        end
      end
    end else if (is_resist) begin
      if (value > 32'sd0) begin
        if (acc_kind != nar_pkg::KIND_KNOWN) begin
          acc_next      = value;
          acc_kind_next = nar_pkg::KIND_KNOWN;
          neg_next      = 32'sd0;
          neg_kind_next = nar_pkg::KIND_KNOWN;
        end else if (acc < value) begin
          acc_next = value;
        end
      end else begin
        if (neg_kind != nar_pkg::KIND_KNOWN) begin
          neg_next      = value;
          neg_kind_next = nar_pkg::KIND_KNOWN;
          acc_next      = 32'sd0;
          acc_kind_next = nar_pkg::KIND_KNOWN;
        end else if (neg > value) begin
          neg_next = value;
        end
      end
    end else if (acc_kind != nar_pkg::KIND_KNOWN) begin
      acc_kind_next = nar_pkg::KIND_KNOWN;
      if (ctl.mode == nar_pkg::MODE_LOGIC_OR) begin
        acc_next = (value != 32'sd0) ? 32'sd1 : 32'sd0;
      end else begin
        acc_next = value;
      end
    end else begin
      acc_next = comb;
    end
  end

  // Result from the updated state; resist lowers a small result by one
  always_comb begin
    result_kind = acc_kind_next;
    if (acc_kind_next != nar_pkg::KIND_KNOWN) begin
      result = 32'sd0;
    end else if (is_resist && (neg_kind_next == nar_pkg::KIND_KNOWN) &&
                 (neg_next < 32'sd0) && (acc_next < nar_pkg::RESIST_LIMIT) &&
                 (acc_next != nar_pkg::VALUE_MIN)) begin
      result = acc_next - 32'sd1;
    end else begin
      result = acc_next;
    end
  end

  // Accumulator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= 32'sd0;
      acc_kind <= nar_pkg::KIND_ABSENT;
      neg      <= 32'sd0;
      neg_kind <= nar_pkg::KIND_ABSENT;
    end else if (ctl.en) begin
      acc      <= acc_next;
      acc_kind <= acc_kind_next;
      neg      <= neg_next;
      neg_kind <= neg_kind_next;
    end
  end

endmodule

/* rtl/null_aware_run_reducer.sv */
// Top level of the null-aware run reducer: input register, two lanes, result register.
// Path: a run-end transaction goes from the input register through the lane update
//   into the result register, which drives the result outputs.
// Throughput: one transaction per cycle while the output is not stalled; the single
//   lane update pass between the two registers sets this figure.
// Reset (rst, synchronous): mode 0, all accumulators absent with value 0, both stages empty.
module null_aware_run_reducer (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] main_value,
  input  logic [1:0]         main_kind,
  input  logic signed [31:0] aux_value,
  input  logic [1:0]         aux_kind,
  input  logic               starts_run,
  input  logic               ends_run,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] main_result,
  output logic [1:0]         main_result_kind,
  output logic signed [31:0] aux_result,
  output logic [1:0]         aux_result_kind
);

  logic [2:0]         mode;

  logic               s1_valid;
  logic signed [31:0] s1_main_value;
  logic [1:0]         s1_main_kind;
  logic signed [31:0] s1_aux_value;
  logic [1:0]         s1_aux_kind;
  logic               s1_start;
  logic               s1_end;
  logic               s1_take;
  logic               in_take;

  nar_pkg::lane_ctl_t lane_ctl;
  logic signed [31:0] main_res, aux_res;
  logic [1:0]         main_res_kind, aux_res_kind;

  // Mode register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= nar_pkg::MODE_ADD;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Stage 1 moves on unless it must emit into a full, stalled result register
  assign s1_take  = s1_valid && (!s1_end || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_take;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_main_value <= main_value;
      s1_main_kind  <= main_kind;
      s1_aux_value  <= aux_value;
      s1_aux_kind   <= aux_kind;
      s1_start      <= starts_run;
      s1_end        <= ends_run;
    end
  end

  // Lane update control
  assign lane_ctl = '{en: s1_take, start: s1_start, mode: mode};

  nar_lane u_main (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lane_ctl),
    .value       (s1_main_value),
    .kind        (s1_main_kind),
    .result      (main_res),
    .result_kind (main_res_kind)
  );

  nar_lane u_aux (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lane_ctl),
    .value       (s1_aux_value),
    .kind        (s1_aux_kind),
    .result      (aux_res),
    .result_kind (aux_res_kind)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take && s1_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_end) begin
      main_result      <= main_res;
      main_result_kind <= main_res_kind;
      aux_result       <= aux_res;
      aux_result_kind  <= aux_res_kind;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_take && s1_end) |=> out_valid)
    else $error("run end did not produce a result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_end && out_valid && out_stall) |-> !s1_take)
    else $error("result overwritten while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (main_result_kind != 2'd3) && (aux_result_kind != 2'd3))
    else $error("illegal result kind");

  a_zero_unless_known: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (main_result_kind != nar_pkg::KIND_KNOWN)) |-> (main_result == 32'sd0))
    else $error("non-known main result carries a value");

endmodule
